// ----- rtl/core/frx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types, codes and constants of the framed serial link receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_RD,
        ST_STAT,
        ST_DROP
    } state_t;

    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_RESP,
        OUT_STAT,
        OUT_DROP
    } outcome_t;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;

    localparam logic [1:0] RSN_CHECKSUM = 2'd0;
    localparam logic [1:0] RSN_TEXT     = 2'd1;
    localparam logic [1:0] RSN_UNKNOWN  = 2'd2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] CFG_STATUS_ID  = 3'd0;
    localparam logic [2:0] CFG_REQUEST_ID = 3'd1;
    localparam logic [2:0] CFG_RESPONSE_ID = 3'd2;
    localparam logic [2:0] CFG_STATUS_LEN = 3'd3;
    localparam logic [2:0] CFG_INTERVAL   = 3'd4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned RESULT_CAP = 32;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned HS_TEXT_LEN = 5;
    localparam int unsigned RESP_LEN   = 8;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned S_USER_W   = 1;
    localparam int unsigned M_DATA_W   = 48;
    localparam int unsigned M_USER_W   = 2;

    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_2 = 8'h32;
    localparam logic [7:0] CH_L = 8'h4C;

    localparam logic [7:0] RESP_TEXT_SUM = 8'(CH_L + CH_D + CH_2 + CH_N + CH_D);

    typedef struct packed {
        logic       in_ready;
        logic       rd_en;
        logic       load_out;
        logic [1:0] out_kind;
    } cmd_t;

    typedef struct packed {
        outcome_t outcome;
        logic     last;
        logic     out_free;
    } sts_t;

    // expected request text "ND2LD"
    function automatic logic [7:0] req_text(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = CH_N;
            3'd1: ch = CH_D;
            3'd2: ch = CH_2;
            3'd3: ch = CH_L;
            3'd4: ch = CH_D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // response: id, length, "LD2ND", checksum
    function automatic logic [7:0] resp_byte(input logic [2:0] idx,
                                             input logic [7:0] resp_id);
        logic [7:0] sum;
        logic [7:0] ch;
        sum = resp_id + 8'(HS_TEXT_LEN) + RESP_TEXT_SUM;
        case (idx)
            3'd0: ch = resp_id;
            3'd1: ch = 8'(HS_TEXT_LEN);
            3'd2: ch = CH_L;
            3'd3: ch = CH_D;
            3'd4: ch = CH_2;
            3'd5: ch = CH_N;
            3'd6: ch = CH_D;
            default: ch = ~sum;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/frx_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frx_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/frx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frx_ctrl
// Sequencer: takes one word, then walks its results out one at a time.
// ----------------------------------------------------------------------------
module frx_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire frx_pkg::sts_t sts,
    output frx_pkg::cmd_t      cmd
);

    frx_pkg::state_t state_reg;
    frx_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frx_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            frx_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (sts.outcome)
                        frx_pkg::OUT_RESP: state_next = frx_pkg::ST_RESP;
                        frx_pkg::OUT_STAT: state_next = frx_pkg::ST_RD;
                        frx_pkg::OUT_DROP: state_next = frx_pkg::ST_DROP;
                        default:           state_next = frx_pkg::ST_IDLE;
                    endcase
                end
            end
            frx_pkg::ST_RESP: begin
                if (sts.out_free && sts.last) begin
                    state_next = frx_pkg::ST_IDLE;
                end
            end
            frx_pkg::ST_RD: begin
                state_next = frx_pkg::ST_STAT;
            end
            frx_pkg::ST_STAT: begin
                if (sts.out_free) begin
                    state_next = sts.last ? frx_pkg::ST_IDLE : frx_pkg::ST_RD;
                end
            end
            frx_pkg::ST_DROP: begin
                if (sts.out_free) begin
                    state_next = frx_pkg::ST_IDLE;
                end
            end
            default: state_next = frx_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.out_kind = frx_pkg::KIND_TX;
        case (state_reg)
            frx_pkg::ST_IDLE: begin
                cmd.in_ready = 1'b1;
            end
            frx_pkg::ST_RESP: begin
                cmd.out_kind = frx_pkg::KIND_TX;
                cmd.load_out = sts.out_free;
            end
            frx_pkg::ST_RD: begin
                cmd.out_kind = frx_pkg::KIND_STATUS;
                cmd.rd_en    = 1'b1;
            end
            frx_pkg::ST_STAT: begin
                cmd.out_kind = frx_pkg::KIND_STATUS;
                cmd.load_out = sts.out_free;
            end
            frx_pkg::ST_DROP: begin
                cmd.out_kind = frx_pkg::KIND_DROP;
                cmd.load_out = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/frx_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frx_dp
// Datapath: config registers, frame parser, ms timer, payload RAM and the
// output register.
// ----------------------------------------------------------------------------
module frx_dp #(
    parameter int unsigned MAX_STATUS_BYTES = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [frx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [frx_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_tvalid,
    input  wire logic [frx_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire logic [frx_pkg::S_USER_W-1:0]       s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [frx_pkg::M_DATA_W-1:0]       m_tdata,
    output logic      [frx_pkg::M_USER_W-1:0]       m_tuser,
    output logic                                    m_tlast,
    input  wire frx_pkg::cmd_t                      cmd,
    output frx_pkg::sts_t                           sts
);

    localparam int unsigned ADDR_W     = $clog2(MAX_STATUS_BYTES);
    localparam int unsigned STAT_LIMIT = (MAX_STATUS_BYTES < frx_pkg::RESULT_CAP) ?
                                         MAX_STATUS_BYTES : frx_pkg::RESULT_CAP;

    // config
    logic [7:0]  status_id_reg;
    logic [7:0]  request_id_reg;
    logic [7:0]  response_id_reg;
    logic [5:0]  status_len_reg;
    logic [15:0] interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_id_reg   <= 8'd1;
            request_id_reg  <= 8'd16;
            response_id_reg <= 8'd17;
            status_len_reg  <= 6'd8;
            interval_reg    <= 16'd2500;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                frx_pkg::CFG_STATUS_ID:   status_id_reg   <= cfg_wdata[7:0];
                frx_pkg::CFG_REQUEST_ID:  request_id_reg  <= cfg_wdata[7:0];
                frx_pkg::CFG_RESPONSE_ID: response_id_reg <= cfg_wdata[7:0];
                frx_pkg::CFG_STATUS_LEN:  status_len_reg  <= cfg_wdata[5:0];
                frx_pkg::CFG_INTERVAL:    interval_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // parser and timer state
    frx_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  sum_reg, sum_next;
    logic        text_ok_reg, text_ok_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] since_reg, since_next;
    logic [frx_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [1:0]  reason_reg, reason_next;

    logic        accept;
    logic        is_tick;
    logic [7:0]  rx_byte;
    logic [15:0] since_inc;
    logic [7:0]  cnt_inc;
    logic        status_match;
    logic        ram_we;
    logic [7:0]  ram_rdata;
    frx_pkg::outcome_t outcome;
    logic [1:0]  reason;

    assign accept    = s_tvalid && cmd.in_ready;
    assign is_tick   = (s_tuser[0] == frx_pkg::REQ_TICK);
    assign rx_byte   = s_tdata[7:0];
    assign since_inc = (since_reg == 16'hFFFF) ? since_reg : since_reg + 16'd1;
    assign cnt_inc   = cnt_reg + 8'd1;

    assign status_match = (id_reg == status_id_reg) && (len_reg == {2'b00, status_len_reg})
                          && (status_len_reg != 6'd0)
                          && ({1'b0, status_len_reg} <= 7'(STAT_LIMIT));

    always_comb begin
        outcome = frx_pkg::OUT_NONE;
        reason  = frx_pkg::RSN_CHECKSUM;
        if (is_tick) begin
            if (since_inc >= interval_reg) begin
                outcome = frx_pkg::OUT_RESP;
            end
        end else if (phase_reg == frx_pkg::PH_CHECK) begin
            if (~sum_reg != rx_byte) begin
                outcome = frx_pkg::OUT_DROP;
                reason  = frx_pkg::RSN_CHECKSUM;
            end else if (status_match) begin
                outcome = frx_pkg::OUT_STAT;
            end else if (id_reg == request_id_reg && len_reg == 8'(frx_pkg::HS_TEXT_LEN)) begin
                if (text_ok_reg) begin
                    outcome = frx_pkg::OUT_RESP;
                end else begin
                    outcome = frx_pkg::OUT_DROP;
                    reason  = frx_pkg::RSN_TEXT;
                end
            end else begin
                outcome = frx_pkg::OUT_DROP;
                reason  = frx_pkg::RSN_UNKNOWN;
            end
        end
    end

    assign ram_we = accept && !is_tick && (phase_reg == frx_pkg::PH_PAYLOAD)
                    && (cnt_reg < 8'(MAX_STATUS_BYTES));

    always_comb begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        text_ok_next = text_ok_reg;
        time_next    = time_reg;
        since_next   = since_reg;
        idx_next     = idx_reg;
        stamp_next   = stamp_reg;
        reason_next  = reason_reg;
        if (accept) begin
            idx_next    = '0;
            stamp_next  = time_reg;
            reason_next = reason;
            if (is_tick) begin
                time_next  = time_reg + 32'd1;
                since_next = (outcome == frx_pkg::OUT_RESP) ? 16'd0 : since_inc;
            end else begin
                case (phase_reg)
                    frx_pkg::PH_ID: begin
                        id_next      = rx_byte;
                        sum_next     = rx_byte;
                        cnt_next     = 8'd0;
                        text_ok_next = 1'b1;
                        phase_next   = frx_pkg::PH_LEN;
                    end
                    frx_pkg::PH_LEN: begin
                        len_next   = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                        phase_next = (rx_byte == 8'd0) ? frx_pkg::PH_CHECK
                                                       : frx_pkg::PH_PAYLOAD;
                    end
                    frx_pkg::PH_PAYLOAD: begin
                        sum_next = sum_reg + rx_byte;
                        cnt_next = cnt_inc;
                        if (cnt_reg < 8'(frx_pkg::HS_TEXT_LEN)
                            && rx_byte != frx_pkg::req_text(cnt_reg[2:0])) begin
                            text_ok_next = 1'b0;
                        end
                        if (cnt_inc >= len_reg) begin
                            phase_next = frx_pkg::PH_CHECK;
                        end
                    end
                    default: begin
                        phase_next = frx_pkg::PH_ID;
                    end
                endcase
            end
        end else if (cmd.load_out) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= frx_pkg::PH_ID;
            id_reg      <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            text_ok_reg <= 1'b0;
            time_reg    <= '0;
            since_reg   <= '0;
            idx_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            text_ok_reg <= text_ok_next;
            time_reg    <= time_next;
            since_reg   <= since_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg  <= stamp_next;
        reason_reg <= reason_next;
    end

    frx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_STATUS_BYTES)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ADDR_W'(cnt_reg)),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (ram_rdata)
    );

    // result assembly
    logic        last;
    logic [7:0]  out_value;
    logic [4:0]  out_index;
    logic [1:0]  out_reason;
    logic [31:0] out_stamp;

    always_comb begin
        last       = 1'b1;
        out_value  = 8'd0;
        out_index  = 5'd0;
        out_reason = frx_pkg::RSN_CHECKSUM;
        out_stamp  = 32'd0;
        case (cmd.out_kind)
            frx_pkg::KIND_TX: begin
                last      = (idx_reg == 5'(frx_pkg::RESP_LEN - 1));
                out_value = frx_pkg::resp_byte(idx_reg[2:0], response_id_reg);
                out_index = idx_reg;
            end
            frx_pkg::KIND_STATUS: begin
                last      = ({1'b0, idx_reg} == status_len_reg - 6'd1);
                out_value = ram_rdata;
                out_index = idx_reg;
                out_stamp = stamp_reg;
            end
            default: begin
                out_reason = reason_reg;
            end
        endcase
    end

    logic                         out_valid_reg, out_valid_next;
    logic [frx_pkg::M_DATA_W-1:0] out_data_reg;
    logic [frx_pkg::M_USER_W-1:0] out_user_reg;
    logic                         out_last_reg;

    assign out_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {1'b0, out_stamp, out_reason, out_index, out_value};
            out_user_reg <= cmd.out_kind;
            out_last_reg <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign sts.outcome  = outcome;
    assign sts.last     = last;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

// ----- rtl/core/framed_serial_link_receiver_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// framed_serial_link_receiver_core
// Frame parser for a serial link with checksum, status payload delivery and a
// periodic handshake response.
// ----------------------------------------------------------------------------
// Input stream: one word per received byte (s_tuser = 0) or per 1 ms tick
// (s_tuser = 1). Output stream: transmit bytes, status payload bytes or one
// drop word per bad frame; m_tlast marks the last word caused by an input.
// Config is a plain write port; the user must use it only while the core is
// idle, the core does not enforce this. Sequence: a word that causes no
// result leaves the core ready. A word that causes a response holds the
// input in the RESP state, which loads one byte per cycle from a constant
// table while the output register is free. A status frame holds it for an
// RD state then a STAT state per payload byte, set by the registered payload
// RAM read. A drop holds it in the DROP state until its drop word is loaded.
// s_tready is high only while no results are pending inside the core; the
// output register lets the next word enter while the last result still waits.
// When m_tready is low the sequencer holds and nothing is lost.
// Reset clears parser state, the timer and config to defaults; the payload
// RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module framed_serial_link_receiver_core #(
    parameter int unsigned MAX_STATUS_BYTES = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [frx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [frx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [frx_pkg::S_DATA_W-1:0]    s_tdata,  // rx_byte[7:0]
    input  wire logic [frx_pkg::S_USER_W-1:0]    s_tuser,  // req_type[0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // byte_value[7:0], byte_index[12:8], drop_reason[14:13], stamp_ms[46:15]
    output logic      [frx_pkg::M_DATA_W-1:0]    m_tdata,
    output logic      [frx_pkg::M_USER_W-1:0]    m_tuser,  // result_kind[1:0]
    output logic                                 m_tlast   // last_of_run
);

    frx_pkg::cmd_t cmd;
    frx_pkg::sts_t sts;

    frx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    frx_dp #(
        .MAX_STATUS_BYTES (MAX_STATUS_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign s_tready = cmd.in_ready;

    // never overwrite a word the sink has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output word overwritten");

    // no result is produced in the cycle a word is taken
    a_ready_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.load_out)
        else $error("result loaded while taking input");

    // a word without results leaves the core ready
    a_none_stays_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.outcome == frx_pkg::OUT_NONE) |=> s_tready)
        else $error("core stalled on a word without results");

endmodule
`default_nettype wire

// ----- bench/tb_framed_serial_link_receiver_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_framed_serial_link_receiver_core
// Self-checking bench for the framed serial link receiver. Byte and tick words
// are queued per configuration phase and fed by a clocked driver with random
// gaps. A shadow parser predicts every output word as inputs are accepted,
// and a monitor checks the output stream in order against it while the sink
// stalls at random and, once, for a long stretch.
// ----------------------------------------------------------------------------
module tb_framed_serial_link_receiver_core;
    import frx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PAYLOAD = 32;
    localparam int unsigned BODY_IDX_W = $clog2(MAX_PAYLOAD);
    // "ND2LD" and "LD2ND", first character in the low byte
    localparam logic [39:0] ASK_TEXT   = {CH_D, CH_L, CH_2, CH_D, CH_N};
    localparam logic [39:0] REPLY_TEXT = {CH_D, CH_N, CH_2, CH_D, CH_L};

    typedef struct packed {
        logic       tick;
        logic [7:0] data;
    } link_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [4:0]  index;
        logic [1:0]  reason;
        logic [31:0] stamp;
        logic        last;
    } link_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;   // rx_byte[7:0]
    logic [S_USER_W-1:0]   s_tuser = '0;   // req_type[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // byte_value[7:0], byte_index[12:8], drop_reason[14:13], stamp_ms[46:15]
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;        // result_kind[1:0]
    logic                  m_tlast;

    framed_serial_link_receiver_core #(
        .MAX_STATUS_BYTES(MAX_PAYLOAD)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // stimulus and expected output
    link_word_t   pending_words[$];
    link_result_t expected_out[$];
    logic [7:0]   frame_body[$];
    int           words_queued = 0;
    int           words_taken = 0;
    int           error_count = 0;

    // idling control
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int hold_left = 0;
    bit long_hold_due = 1'b0;
    bit long_hold_done = 1'b0;

    // register shadow
    logic [7:0]  status_id_cfg = 8'd1;
    logic [7:0]  request_id_cfg = 8'd16;
    logic [7:0]  reply_id_cfg = 8'd17;
    logic [5:0]  status_len_cfg = 6'd8;
    logic [15:0] interval_cfg = 16'd2500;

    // shadow parser and timer
    phase_t      parse_phase = PH_ID;
    logic [7:0]  cur_id = '0;
    logic [7:0]  cur_len = '0;
    logic [7:0]  body_count = '0;
    logic [7:0]  cur_sum = '0;
    logic [7:0]  body_mem [0:MAX_PAYLOAD-1];
    logic [31:0] clock_ms = '0;
    logic [15:0] idle_ms = '0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    task automatic emit(input logic [1:0] kind, input logic [7:0] value,
                        input logic [4:0] idx, input logic [1:0] reason,
                        input logic [31:0] stamp, input logic last);
        expected_out.push_back({kind, value, idx, reason, stamp, last});
    endtask

    task automatic queue_reply();
        logic [7:0] sum;
        logic [7:0] ch;
        sum = reply_id_cfg + 8'(HS_TEXT_LEN);
        emit(KIND_TX, reply_id_cfg, 5'd0, '0, '0, 1'b0);
        emit(KIND_TX, 8'(HS_TEXT_LEN), 5'd1, '0, '0, 1'b0);
        for (int i = 0; i < HS_TEXT_LEN; i++) begin
            ch = REPLY_TEXT[8*i +: 8];
            sum = sum + ch;
            emit(KIND_TX, ch, 5'(i + 2), '0, '0, 1'b0);
        end
        emit(KIND_TX, ~sum, 5'd7, '0, '0, 1'b1);
    endtask

    task automatic close_frame(input logic [7:0] check);
        logic [7:0] want_check;
        logic       text_ok;
        want_check = ~cur_sum;
        text_ok = 1'b1;
        if (want_check != check) begin
            emit(KIND_DROP, '0, '0, RSN_CHECKSUM, '0, 1'b1);
        end else if (cur_id == status_id_cfg && cur_len == 8'(status_len_cfg) &&
                     status_len_cfg >= 6'd1 && status_len_cfg <= 6'(MAX_PAYLOAD)) begin
            for (int i = 0; i < int'(status_len_cfg); i++)
                emit(KIND_STATUS, body_mem[i], 5'(i), '0, clock_ms,
                     i == int'(status_len_cfg) - 1);
        end else if (cur_id == request_id_cfg && cur_len == 8'(HS_TEXT_LEN)) begin
            for (int i = 0; i < HS_TEXT_LEN; i++)
                if (body_mem[i] != ASK_TEXT[8*i +: 8]) text_ok = 1'b0;
            if (text_ok)
                queue_reply();
            else
                emit(KIND_DROP, '0, '0, RSN_TEXT, '0, 1'b1);
        end else begin
            emit(KIND_DROP, '0, '0, RSN_UNKNOWN, '0, 1'b1);
        end
    endtask

    task automatic parse_word(input link_word_t w);
        if (w.tick == REQ_TICK) begin
            clock_ms = clock_ms + 32'd1;
            if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
            if (idle_ms >= interval_cfg) begin
                queue_reply();
                idle_ms = '0;
            end
        end else begin
            case (parse_phase)
                PH_ID: begin
                    cur_id = w.data;
                    cur_sum = w.data;
                    body_count = '0;
                    parse_phase = PH_LEN;
                end
                PH_LEN: begin
                    cur_len = w.data;
                    cur_sum = cur_sum + w.data;
                    parse_phase = (w.data == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (body_count < 8'(MAX_PAYLOAD))
                        body_mem[body_count[BODY_IDX_W-1:0]] = w.data;
                    cur_sum = cur_sum + w.data;
                    body_count = body_count + 8'd1;
                    if (body_count >= cur_len) parse_phase = PH_CHECK;
                end
                default: begin
                    close_frame(w.data);
                    parse_phase = PH_ID;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_word({s_tuser[0], s_tdata});
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    link_word_t w;
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.tick;
                    s_tdata <= w.data;
                    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
                        src_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sink and monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct)
                snk_gap = $urandom_range(1, 16);
        end
    end

    function automatic string fmt_result(input link_result_t r);
        return $sformatf("kind=%0d value=%02h index=%0d reason=%0d stamp=%0d last=%0d",
                         r.kind, r.value, r.index, r.reason, r.stamp, r.last);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            link_result_t got;
            link_result_t want;
            got = {m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[14:13],
                   m_tdata[46:15], m_tlast};
            if (expected_out.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("[%0t] unexpected word: %s", $realtime, fmt_result(got));
            end else begin
                want = expected_out.pop_front();
                if (got.kind !== want.kind || got.value !== want.value ||
                    got.index !== want.index || got.reason !== want.reason ||
                    got.stamp !== want.stamp || got.last !== want.last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("[%0t] mismatch", $realtime);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_word(input logic tick, input logic [7:0] data);
        pending_words.push_back({tick, data});
        words_queued++;
    endtask

    task automatic maybe_tick(input int pct);
        if (pct > 0 && $urandom_range(0, 99) < pct) push_word(REQ_TICK, 8'($urandom));
    endtask

    // id, length, frame_body, checksum; tick_at puts a tick before that body byte
    task automatic add_frame(input logic [7:0] id, input bit bad_sum,
                             input int tick_pct, input int tick_at);
        logic [7:0] sum;
        sum = id + 8'(frame_body.size());
        push_word(REQ_BYTE, id);
        maybe_tick(tick_pct);
        push_word(REQ_BYTE, 8'(frame_body.size()));
        for (int i = 0; i < frame_body.size(); i++) begin
            if (i == tick_at) push_word(REQ_TICK, 8'($urandom));
            maybe_tick(tick_pct);
            push_word(REQ_BYTE, frame_body[i]);
            sum = sum + frame_body[i];
        end
        maybe_tick(tick_pct);
        push_word(REQ_BYTE, bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_STATUS_ID:   status_id_cfg = val[7:0];
            CFG_REQUEST_ID:  request_id_cfg = val[7:0];
            CFG_RESPONSE_ID: reply_id_cfg = val[7:0];
            CFG_STATUS_LEN:  status_len_cfg = val[5:0];
            CFG_INTERVAL:    interval_cfg = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || expected_out.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [7:0] sid, input logic [7:0] rid,
                             input logic [7:0] pid, input logic [5:0] slen,
                             input logic [15:0] ivl, input int src_pct,
                             input int snk_pct, input int budget, input bit hold);
        int start;
        int sel;
        int k;
        set_reg(CFG_STATUS_ID, {8'd0, sid});
        set_reg(CFG_REQUEST_ID, {8'd0, rid});
        set_reg(CFG_RESPONSE_ID, {8'd0, pid});
        set_reg(CFG_STATUS_LEN, {10'd0, slen});
        set_reg(CFG_INTERVAL, ivl);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start = words_queued;
        while (words_queued - start < budget) begin
            sel = $urandom_range(0, 99);
            frame_body.delete();
            if (sel < 35) begin
                repeat (int'(status_len_cfg)) frame_body.push_back(8'($urandom));
                add_frame(status_id_cfg, $urandom_range(0, 19) == 0, 8, -1);
            end else if (sel < 55) begin
                for (int i = 0; i < HS_TEXT_LEN; i++)
                    frame_body.push_back(ASK_TEXT[8*i +: 8]);
                if ($urandom_range(0, 2) == 0) begin
                    k = $urandom_range(0, HS_TEXT_LEN - 1);
                    frame_body[k] = frame_body[k] ^ 8'($urandom_range(1, 255));
                end
                add_frame(request_id_cfg, $urandom_range(0, 19) == 0, 8, -1);
            end else if (sel < 70) begin
                repeat ($urandom_range(1, 4)) push_word(REQ_TICK, 8'($urandom));
            end else if (sel < 85) begin
                repeat ($urandom_range(0, 6)) frame_body.push_back(8'($urandom));
                add_frame(8'($urandom), $urandom_range(0, 3) == 0, 5, -1);
            end else if (sel < 95) begin
                repeat ($urandom_range(0, 8)) frame_body.push_back(8'($urandom));
                add_frame($urandom_range(0, 1) ? status_id_cfg : request_id_cfg,
                          $urandom_range(0, 4) == 0, 5, -1);
            end else begin
                // longer than the payload store
                repeat ($urandom_range(33, 40)) frame_body.push_back(8'($urandom));
                add_frame($urandom_range(0, 1) ? status_id_cfg : 8'($urandom),
                          $urandom_range(0, 1) == 0, 3, -1);
            end
        end
        if (hold) long_hold_due = 1'b1;
        wait_idle();
    endtask

    initial begin
        logic [7:0] same_id;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one-byte status, periodic reply, request with a tick
        // inside, reply after request, bad text, unknown zero length, bad sum
        set_reg(CFG_STATUS_LEN, 16'd1);
        set_reg(CFG_INTERVAL, 16'd2);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        src_idle_pct = 15;
        snk_idle_pct = 15;
        frame_body = '{8'hFF};
        add_frame(status_id_cfg, 1'b0, 0, -1);
        push_word(REQ_TICK, 8'h00);
        push_word(REQ_TICK, 8'hFF);
        frame_body = '{CH_N, CH_D, CH_2, CH_L, CH_D};
        add_frame(request_id_cfg, 1'b0, 0, 2);
        push_word(REQ_TICK, 8'h5A);
        frame_body = '{CH_N, CH_D, CH_2, CH_L, 8'h45};
        add_frame(request_id_cfg, 1'b0, 0, -1);
        frame_body.delete();
        add_frame(8'h80, 1'b0, 0, -1);
        add_frame(8'h00, 1'b1, 0, -1);
        wait_idle();

        // out-of-range status length, reply on every tick
        run_phase(8'h00, 8'hFF, 8'h00, 6'd0, 16'd0, 0, 30, 60, 1'b0);
        run_phase(8'hFF, 8'h00, 8'hFF, 6'd45, 16'd1, 30, 0, 60, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 6'd1, 16'hFFFF,
                  20, 20, 60, 1'b0);
        // status and request share an id
        same_id = 8'($urandom);
        run_phase(same_id, same_id, 8'($urandom), 6'd32, 16'd3, 10, 25, 60, 1'b1);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom),
                  6'($urandom_range(1, 32)), 16'($urandom_range(5, 40)),
                  25, 10, 60, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom),
                  6'($urandom_range(2, 12)), 16'($urandom_range(20, 80)),
                  0, 0, 60, 1'b0);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
